@@ src/mst_pkg.sv @@
// Package for the MAC sighting table: field widths, the stored row layout and
// the command and status groups that join the controller and the datapath.
// No dependencies.
package mst_pkg;

  localparam int unsigned DefTableDepth = 64;

  localparam int unsigned MacW   = 48;
  localparam int unsigned TickW  = 32;
  localparam int unsigned CountW = 16;
  localparam int unsigned RssiW  = 8;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned ConfW  = 2;
  localparam int unsigned ClassW = 4;
  localparam int unsigned AttrW  = 7;
  localparam int unsigned SlotW  = 6;

  // One sighting as latched at acceptance. Attributes are packed as
  // {radio_source, device_class, confidence_level}.
  typedef struct packed {
    logic [MacW-1:0]  mac;
    logic [TickW-1:0] now;
    logic [RssiW-1:0] rssi;
    logic [ChanW-1:0] chan;
    logic [AttrW-1:0] attr;
  } mst_item_t;

  // One table row as held in the entry memory.
  typedef struct packed {
    logic [MacW-1:0]   mac;
    logic [TickW-1:0]  first_seen;
    logic [TickW-1:0]  last_seen;
    logic [CountW-1:0] sightings;
    logic [RssiW-1:0]  rssi;
    logic [ChanW-1:0]  chan;
    logic [AttrW-1:0]  attr;
  } mst_row_t;

  // One result transaction.
  typedef struct packed {
    logic [SlotW-1:0]  slot_index;
    logic              was_new;
    logic              was_evicted;
    logic [MacW-1:0]   evicted_mac;
    logic [CountW-1:0] sighting_count;
    logic [TickW-1:0]  first_seen;
  } mst_result_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic commit;
  } mst_cmd_t;

  typedef struct packed {
    logic empty;
    logic scan_done;
    logic out_free;
  } mst_status_t;

endpackage

@@ src/mst_if.sv @@
// Valid/ready channel interfaces for sightings in and table results out.
// Depends on mst_pkg for field widths.
interface mst_in_if import mst_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [MacW-1:0]         mac_address;
  logic [TickW-1:0]        now_tick;
  logic signed [RssiW-1:0] signal_rssi;
  logic [ChanW-1:0]        radio_channel;
  logic [ConfW-1:0]        confidence_level;
  logic [ClassW-1:0]       device_class;
  logic                    radio_source;

  modport source (output valid, mac_address, now_tick, signal_rssi, radio_channel,
                  confidence_level, device_class, radio_source, input ready);
  modport sink (input valid, mac_address, now_tick, signal_rssi, radio_channel,
                confidence_level, device_class, radio_source, output ready);
endinterface

interface mst_out_if import mst_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SlotW-1:0]  slot_index;
  logic              was_new;
  logic              was_evicted;
  logic [MacW-1:0]   evicted_mac;
  logic [CountW-1:0] sighting_count;
  logic [TickW-1:0]  first_seen;

  modport source (output valid, slot_index, was_new, was_evicted, evicted_mac,
                  sighting_count, first_seen, input ready);
  modport sink (input valid, slot_index, was_new, was_evicted, evicted_mac,
                sighting_count, first_seen, output ready);
endinterface

@@ src/mst_ctrl.sv @@
// Controller state machine of the MAC sighting table.
// Depends on mst_pkg for the command and status groups.
module mst_ctrl import mst_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  mst_status_t status_i,
  output mst_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StCommit
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          // An empty table cannot hit, so the sighting goes straight to slot zero.
          state_d = status_i.empty ? StCommit : StScan;
        end
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_done) begin
          state_d = StCommit;
        end
      end
      StCommit: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign in_ready_o = (state_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ src/mst_datapath.sv @@
// Datapath of the MAC sighting table: entry memory, scan pointer, hit and
// oldest-entry tracking, fill count and the result register.
// Depends on mst_pkg for row, item, result, command and status types.
module mst_datapath import mst_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DefTableDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  mst_cmd_t    cmd_i,
  output mst_status_t status_o,
  input  mst_item_t   item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output mst_result_t result_o
);

  localparam int unsigned AddrW = $clog2(TABLE_DEPTH);
  localparam int unsigned FillW = AddrW + 1;

  mst_row_t mem_q [TABLE_DEPTH];

  mst_item_t         item_q;
  logic [FillW-1:0]  rd_addr_q;
  logic [FillW-1:0]  filled_q;
  logic              chk_valid_q;
  logic [AddrW-1:0]  chk_idx_q;
  mst_row_t          rdata_q;
  logic              hit_q;
  logic [AddrW-1:0]  hit_slot_q;
  logic [TickW-1:0]  hit_first_q;
  logic [CountW-1:0] hit_cnt_q;
  logic [AddrW-1:0]  best_slot_q;
  logic [TickW-1:0]  best_last_q;
  logic [MacW-1:0]   best_mac_q;
  logic              out_valid_q;
  mst_result_t       out_q;

  logic              rd_en;
  logic              chk_match;
  logic              chk_last;
  logic              chk_better;
  logic              full;
  logic [AddrW-1:0]  wr_slot;
  mst_row_t          wr_row;
  mst_result_t       result_d;
  logic [AddrW+SlotW-1:0] slot_ext;

  assign rd_en      = cmd_i.scan && (rd_addr_q < filled_q);
  assign chk_match  = chk_valid_q && (rdata_q.mac == item_q.mac);
  assign chk_last   = chk_valid_q && (({1'b0, chk_idx_q} + FillW'(1)) == filled_q);
  // Strict less-than keeps the lowest slot among equal oldest times.
  assign chk_better = (chk_idx_q == '0) || (rdata_q.last_seen < best_last_q);
  assign full       = (filled_q == FillW'(TABLE_DEPTH));

  assign status_o.empty     = (filled_q == '0);
  assign status_o.scan_done = chk_match || chk_last;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    wr_row.mac  = item_q.mac;
    wr_row.last_seen = item_q.now;
    wr_row.rssi = item_q.rssi;
    wr_row.chan = item_q.chan;
    wr_row.attr = item_q.attr;
    result_d.was_new     = 1'b1;
    result_d.was_evicted = 1'b0;
    result_d.evicted_mac = '0;
    if (hit_q) begin
      wr_slot              = hit_slot_q;
      wr_row.first_seen    = hit_first_q;
      wr_row.sightings     = (hit_cnt_q == '1) ? hit_cnt_q : hit_cnt_q + CountW'(1);
      result_d.was_new     = 1'b0;
    end else if (!full) begin
      wr_slot              = filled_q[AddrW-1:0];
      wr_row.first_seen    = item_q.now;
      wr_row.sightings     = CountW'(1);
    end else begin
      wr_slot              = best_slot_q;
      wr_row.first_seen    = item_q.now;
      wr_row.sightings     = CountW'(1);
      result_d.was_evicted = 1'b1;
      result_d.evicted_mac = best_mac_q;
    end
    slot_ext                = {{SlotW{1'b0}}, wr_slot};
    result_d.slot_index     = slot_ext[SlotW-1:0];
    result_d.sighting_count = wr_row.sightings;
    result_d.first_seen     = wr_row.first_seen;
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      mem_q[wr_slot] <= wr_row;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr_q[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q    <= '0;
      rd_addr_q   <= '0;
      chk_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        rd_addr_q   <= '0;
        chk_valid_q <= 1'b0;
        hit_q       <= 1'b0;
      end else if (cmd_i.scan) begin
        chk_valid_q <= rd_en;
        if (rd_en) begin
          rd_addr_q <= rd_addr_q + FillW'(1);
        end
        if (chk_match) begin
          hit_q <= 1'b1;
        end
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
        if (!hit_q && !full) begin
          filled_q <= filled_q + FillW'(1);
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      item_q <= item_i;
    end
    if (cmd_i.scan) begin
      if (rd_en) begin
        chk_idx_q <= rd_addr_q[AddrW-1:0];
      end
      if (chk_match) begin
        hit_slot_q  <= chk_idx_q;
        hit_first_q <= rdata_q.first_seen;
        hit_cnt_q   <= rdata_q.sightings;
      end
      if (chk_valid_q && chk_better) begin
        best_slot_q <= chk_idx_q;
        best_last_q <= rdata_q.last_seen;
        best_mac_q  <= rdata_q.mac;
      end
    end
    if (cmd_i.commit) begin
      out_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

endmodule

@@ src/mac_sighting_table.sv @@
// Top level of the MAC sighting table: controller and datapath joined to the
// sighting input channel and the result output channel.
// Depends on mst_pkg, mst_if, mst_ctrl and mst_datapath.

// The block keeps a fully associative table of TABLE_DEPTH radio devices keyed
// by 48-bit MAC address. Each accepted sighting transaction yields exactly one
// result transaction: the slot now holding the device, whether the entry was
// newly created, whether an older entry was replaced (with its address), the
// saturating sighting count and the first-seen tick. A hit updates the entry
// in place; a miss appends while the table has room and otherwise replaces the
// entry with the smallest last-seen tick, lowest slot on a tie. Last-seen ticks
// are compared as plain unsigned values with no wraparound handling. One
// sighting is handled at a time. The table sits in a memory with a single
// registered read port, and one slot is read per cycle while searching: a
// sighting that finds its device at slot k stops the search at that slot, a
// miss reads every filled slot, and a sighting on an empty table skips the
// search. The controller goes back to idle in the cycle that writes the
// result, so the next sighting can be accepted in the cycle after that write.
// A finished result waits in an output register, and the next sighting is
// accepted and searched while it waits; only its final write is held back
// until the output register is free again. Table entries need no clearing
// after reset, since only slots below the fill count are ever read.
module mac_sighting_table import mst_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DefTableDepth
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  mst_in_if.sink    in_i,
  mst_out_if.source out_o
);

  mst_cmd_t    cmd;
  mst_status_t status;
  mst_item_t   item;
  mst_result_t result;
  logic        out_valid;

  // Attributes pack as source, class, confidence from the most significant bit.
  assign item.mac  = in_i.mac_address;
  assign item.now  = in_i.now_tick;
  assign item.rssi = in_i.signal_rssi;
  assign item.chan = in_i.radio_channel;
  assign item.attr = {in_i.radio_source, in_i.device_class, in_i.confidence_level};

  mst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mst_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .item_i      (item),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .result_o    (result)
  );

  assign out_o.valid          = out_valid;
  assign out_o.slot_index     = result.slot_index;
  assign out_o.was_new        = result.was_new;
  assign out_o.was_evicted    = result.was_evicted;
  assign out_o.evicted_mac    = result.evicted_mac;
  assign out_o.sighting_count = result.sighting_count;
  assign out_o.first_seen     = result.first_seen;

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for mac_sighting_table: sends sighting transactions and
// checks every result against a behavioral model of the device table.
// Depends on mst_pkg, the mst_in_if / mst_out_if interfaces and the RTL.
module tb;
  import mst_pkg::*;

  localparam int unsigned Depth       = DefTableDepth;
  localparam int unsigned ClkHalf     = 5;
  localparam int unsigned ResetCycles = 4;
  // No transaction on either side for this long means the block is stuck. The
  // worst honest gap is a full-table search plus random gaps.
  localparam int unsigned StallLimit  = 4000;
  // Quiet cycles after the last result, to catch any stray result.
  localparam int unsigned DrainCycles = 100;
  localparam int unsigned PoolSize    = 96;
  localparam int unsigned MaxShown    = 10;

  // One sighting as the bench sees it, at the widths of the input channel.
  typedef struct packed {
    logic [MacW-1:0]         mac;
    logic [TickW-1:0]        tick;
    logic signed [RssiW-1:0] rssi;
    logic [ChanW-1:0]        chan;
    logic [ConfW-1:0]        conf;
    logic [ClassW-1:0]       cls_code;
    logic                    src;
  } sighting_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mst_in_if  in_if ();
  mst_out_if out_if ();

  mac_sighting_table u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Device table model. Only the fields that shape a result are kept: the
  // address for the search, last-seen for the oldest-entry choice, first-seen
  // and the sighting count for the reported values.
  // ---------------------------------------------------------------------------
  logic [MacW-1:0]   dev_mac   [Depth];
  logic [TickW-1:0]  dev_first [Depth];
  logic [TickW-1:0]  dev_last  [Depth];
  logic [CountW-1:0] dev_count [Depth];
  int unsigned       dev_filled = 0;

  // Applies one sighting to the model and returns the result it must produce.
  function automatic mst_result_t record_sighting(sighting_t s);
    mst_result_t r;
    int unsigned slot;
    bit          found;
    r     = '0;
    slot  = 0;
    found = 1'b0;
    // Search filled slots in order; the first match wins.
    for (int unsigned k = 0; k < dev_filled; k++) begin
      if (!found && dev_mac[k] == s.mac) begin
        slot  = k;
        found = 1'b1;
      end
    end
    if (!found) begin
      r.was_new = 1'b1;
      if (dev_filled < Depth) begin
        slot = dev_filled;
        dev_filled++;
      end else begin
        // Oldest by plain unsigned last-seen; strict less-than keeps the
        // lowest slot on a tie.
        slot = 0;
        for (int unsigned k = 1; k < Depth; k++) begin
          if (dev_last[k] < dev_last[slot]) slot = k;
        end
        r.was_evicted = 1'b1;
        r.evicted_mac = dev_mac[slot];
      end
      dev_mac[slot]   = s.mac;
      dev_first[slot] = s.tick;
      dev_count[slot] = '0;
    end
    dev_last[slot] = s.tick;
    if (dev_count[slot] != '1) dev_count[slot] = dev_count[slot] + 1'b1;
    r.slot_index     = slot[SlotW-1:0];
    r.sighting_count = dev_count[slot];
    r.first_seen     = dev_first[slot];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Queues and counters shared by the stimulus, the driver and the monitor.
  // ---------------------------------------------------------------------------
  sighting_t   pending_q[$];
  mst_result_t expected_q[$];
  int unsigned issued_cnt  = 0;
  int unsigned checked_cnt = 0;
  int unsigned error_cnt   = 0;
  int unsigned send_idle_pct  = 25;
  int unsigned recv_stall_pct = 52;

  sighting_t   next_sighting;
  sighting_t   taken_sighting;
  mst_result_t want;

  // ---------------------------------------------------------------------------
  // Driver: presents queued sightings on the input channel. Valid stays up
  // until the transaction is taken; a new item may follow in the very next
  // cycle, or the sender idles at random.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid            <= 1'b0;
      in_if.mac_address      <= '0;
      in_if.now_tick         <= '0;
      in_if.signal_rssi      <= '0;
      in_if.radio_channel    <= '0;
      in_if.confidence_level <= '0;
      in_if.device_class     <= '0;
      in_if.radio_source     <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        // The model advances in acceptance order, so expectations line up with
        // the order in which results must leave the block.
        taken_sighting = '{mac: in_if.mac_address, tick: in_if.now_tick,
                           rssi: in_if.signal_rssi, chan: in_if.radio_channel,
                           conf: in_if.confidence_level, cls_code: in_if.device_class,
                           src: in_if.radio_source};
        expected_q.push_back(record_sighting(taken_sighting));
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_sighting = pending_q.pop_front();
          in_if.valid            <= 1'b1;
          in_if.mac_address      <= next_sighting.mac;
          in_if.now_tick         <= next_sighting.tick;
          in_if.signal_rssi      <= next_sighting.rssi;
          in_if.radio_channel    <= next_sighting.chan;
          in_if.confidence_level <= next_sighting.conf;
          in_if.device_class     <= next_sighting.cls_code;
          in_if.radio_source     <= next_sighting.src;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Reports one field mismatch; only the first few are printed in full.
  task automatic check_field(string name, logic [63:0] exp_val, logic [63:0] got_val);
    if (exp_val !== got_val) begin
      error_cnt++;
      if (error_cnt <= MaxShown)
        $display("[%0t] result %0d %s: expected %0h, got %0h",
                 $realtime, checked_cnt, name, exp_val, got_val);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: takes result transactions with a randomly stalling ready and
  // compares each with the oldest expectation, field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_q.size() == 0) begin
          error_cnt++;
          if (error_cnt <= MaxShown)
            $display("[%0t] result with no sighting pending: slot %0d",
                     $realtime, out_if.slot_index);
        end else begin
          want = expected_q.pop_front();
          check_field("slot_index", 64'(want.slot_index), 64'(out_if.slot_index));
          check_field("was_new", 64'(want.was_new), 64'(out_if.was_new));
          check_field("was_evicted", 64'(want.was_evicted), 64'(out_if.was_evicted));
          check_field("evicted_mac", 64'(want.evicted_mac), 64'(out_if.evicted_mac));
          check_field("sighting_count", 64'(want.sighting_count),
                      64'(out_if.sighting_count));
          check_field("first_seen", 64'(want.first_seen), 64'(out_if.first_seen));
        end
        checked_cnt++;
      end
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: counts cycles with outstanding work and no transaction on
  // either channel.
  // ---------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        checked_cnt == issued_cnt) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("[%0t] no progress for %0d cycles", $realtime, StallLimit);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  logic [MacW-1:0]  mac_pool [PoolSize];
  logic [TickW-1:0] tick_clock = 32'd100;

  task automatic post_sighting(sighting_t s);
    pending_q.push_back(s);
    issued_cnt++;
  endtask

  task automatic post_fields(logic [MacW-1:0] mac, logic [TickW-1:0] tick,
                             logic [RssiW-1:0] rssi, logic [ChanW-1:0] chan,
                             logic [ConfW-1:0] conf, logic [ClassW-1:0] cls, logic src);
    sighting_t s;
    s = '{mac: mac, tick: tick, rssi: rssi, chan: chan, conf: conf,
          cls_code: cls, src: src};
    post_sighting(s);
  endtask

  // Mostly addresses from a pool a bit larger than the table, so hits, fills
  // and replacements all happen; ticks mostly creep forward with frequent
  // repeats (ties for oldest) and now and then jump anywhere (no wraparound
  // handling in the comparison).
  function automatic sighting_t random_sighting();
    sighting_t s;
    if ($urandom_range(99) < 8)
      s.mac = MacW'({$urandom, $urandom});
    else
      s.mac = mac_pool[$urandom_range(PoolSize-1)];
    if ($urandom_range(39) == 0) begin
      s.tick = $urandom;
    end else begin
      if ($urandom_range(2) != 0) tick_clock = tick_clock + $urandom_range(40, 1);
      s.tick = tick_clock;
    end
    s.rssi     = RssiW'($urandom);
    s.chan     = ChanW'($urandom);
    s.conf     = ConfW'($urandom);
    s.cls_code = ClassW'($urandom);
    s.src      = 1'($urandom);
    return s;
  endfunction

  // Holds off until every issued sighting has produced its result.
  task automatic wait_results_done();
    while (checked_cnt != issued_cnt) @(posedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;

    // Half the pool is unrelated addresses; the other half are one-bit
    // neighbors of a single base, so the search must compare every bit.
    for (int unsigned k = 0; k < PoolSize; k++) begin
      if (k < PoolSize / 2) mac_pool[k] = MacW'({$urandom, $urandom});
      else mac_pool[k] = 48'h5a3c_96e1_0f77 ^ (48'd1 << (k % MacW));
    end

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part on an empty table: field extremes, first insert, hits,
    // near-miss addresses and a tick that moves backwards.
    post_fields('0, '0, 8'h80, 8'd0, 2'd0, 4'd0, 1'b0);
    post_fields('1, '1, 8'h7f, 8'd255, 2'd3, 4'd15, 1'b1);
    post_fields('0, 32'd5, 8'hff, 8'd1, 2'd1, 4'd1, 1'b0);
    post_fields(48'hffff_ffff_fffe, 32'd6, 8'h00, 8'd11, 2'd2, 4'd8, 1'b1);
    post_fields(48'h7fff_ffff_ffff, 32'd7, 8'h01, 8'd6, 2'd3, 4'd7, 1'b0);
    post_fields(48'haaaa_aaaa_aaaa, 32'd8, 8'hc4, 8'd36, 2'd1, 4'd10, 1'b0);
    post_fields(48'h5555_5555_5555, 32'd8, 8'h3c, 8'd149, 2'd2, 4'd5, 1'b1);
    post_fields(48'h8000_0000_0000, 32'd9, 8'hb0, 8'd165, 2'd0, 4'd2, 1'b0);
    post_fields(48'h0000_0000_0001, 32'd9, 8'hd8, 8'd13, 2'd3, 4'd4, 1'b1);
    post_fields(48'h0123_4567_89ab, 32'hffff_fff0, 8'he2, 8'd0, 2'd2, 4'd9, 1'b1);
    post_fields('1, 32'd3, 8'hd0, 8'd44, 2'd1, 4'd14, 1'b0);
    post_fields(48'h0123_4567_89ab, 32'd2, 8'h9c, 8'd48, 2'd3, 4'd3, 1'b0);
    post_fields(48'h5555_5555_5555, 32'd10, 8'h80, 8'd255, 2'd0, 4'd12, 1'b1);
    post_fields(48'h0000_0000_0001, 32'd11, 8'h7f, 8'd64, 2'd2, 4'd6, 1'b0);
    post_fields('0, 32'd12, 8'hc0, 8'd100, 2'd1, 4'd11, 1'b1);
    post_fields(48'hffff_ffff_fffe, 32'd12, 8'h40, 8'd161, 2'd0, 4'd13, 1'b0);

    // Phase one: sender idles lightly, receiver stalls heavily.
    repeat (380) post_sighting(random_sighting());
    wait_results_done();

    // Phase two: the other way round.
    send_idle_pct  = 52;
    recv_stall_pct = 25;
    repeat (380) post_sighting(random_sighting());
    wait_results_done();

    // Phase three: both sides at full rate.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (390) post_sighting(random_sighting());
    wait_results_done();

    repeat (DrainCycles) @(posedge clk_i);

    if (expected_q.size() != 0) begin
      error_cnt++;
      $display("%0d results never arrived", expected_q.size());
    end

    if (error_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
